[hw/rtl/thf_pkg.sv]
// Shared types, constants and helper functions for the Threefish cipher block.
package thf_pkg;

   localparam int MaxWords = 16;
   localparam int KeyWords = MaxWords + 1;
   localparam logic [63:0] KsConst = 64'h1BD11BDAA9FC1A22;

   typedef logic [63:0] word_type;
   typedef logic [3:0]  windex_type;

   // Request codes of the input channel.
   typedef enum logic [1:0] {
      REQ_KEY   = 2'd0,
      REQ_TWEAK = 2'd1,
      REQ_DATA  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   // Configuration register indexes.
   localparam logic CSR_WIDE_BLOCK   = 1'b0;
   localparam logic CSR_DECRYPT_MODE = 1'b1;

   // Last word index and last key-schedule index for each block size.
   localparam windex_type LAST_NARROW = 4'd7;
   localparam windex_type LAST_WIDE   = 4'd15;

   // Last injection index from zero: one before the first round and one after every four rounds.
   localparam logic [4:0] INJ_LAST_NARROW = 5'd18;
   localparam logic [4:0] INJ_LAST_WIDE   = 5'd20;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic inject;
      logic mix;
      logic shift;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic trigger;
      logic wide;
   } status_type;

   localparam logic [5:0] ROT8 [8][4] = '{
      '{6'd46, 6'd36, 6'd19, 6'd37}, '{6'd33, 6'd27, 6'd14, 6'd42},
      '{6'd17, 6'd49, 6'd36, 6'd39}, '{6'd44, 6'd9,  6'd54, 6'd56},
      '{6'd39, 6'd30, 6'd34, 6'd24}, '{6'd13, 6'd50, 6'd10, 6'd17},
      '{6'd25, 6'd29, 6'd39, 6'd43}, '{6'd8,  6'd35, 6'd56, 6'd22}};

   localparam logic [5:0] ROT16 [8][8] = '{
      '{6'd24, 6'd13, 6'd8,  6'd47, 6'd8,  6'd17, 6'd22, 6'd37},
      '{6'd38, 6'd19, 6'd10, 6'd55, 6'd49, 6'd18, 6'd23, 6'd52},
      '{6'd33, 6'd4,  6'd51, 6'd13, 6'd34, 6'd41, 6'd59, 6'd17},
      '{6'd5,  6'd20, 6'd48, 6'd41, 6'd47, 6'd28, 6'd16, 6'd25},
      '{6'd41, 6'd9,  6'd37, 6'd31, 6'd12, 6'd47, 6'd44, 6'd30},
      '{6'd16, 6'd34, 6'd56, 6'd51, 6'd4,  6'd53, 6'd42, 6'd41},
      '{6'd31, 6'd44, 6'd47, 6'd46, 6'd19, 6'd42, 6'd44, 6'd25},
      '{6'd9,  6'd48, 6'd35, 6'd52, 6'd23, 6'd31, 6'd37, 6'd20}};

   localparam logic [3:0] PERM8 [8]   = '{4'd2, 4'd1, 4'd4, 4'd7, 4'd6, 4'd5, 4'd0, 4'd3};
   localparam logic [3:0] IPERM8 [8]  = '{4'd6, 4'd1, 4'd0, 4'd7, 4'd2, 4'd5, 4'd4, 4'd3};
   localparam logic [3:0] PERM16 [16] = '{4'd0, 4'd9, 4'd2, 4'd13, 4'd6, 4'd11, 4'd4, 4'd15,
                                          4'd10, 4'd7, 4'd12, 4'd3, 4'd14, 4'd5, 4'd8, 4'd1};
   localparam logic [3:0] IPERM16 [16] = '{4'd0, 4'd15, 4'd2, 4'd11, 4'd6, 4'd13, 4'd4, 4'd9,
                                           4'd14, 4'd1, 4'd8, 4'd5, 4'd10, 4'd3, 4'd12, 4'd7};

   // Rotation amount of pair j in round d.
   function automatic logic [5:0] rot_amt(input logic wide, input logic [2:0] d,
                                          input logic [2:0] j);
      return wide ? ROT16[d][j] : ROT8[d][j[1:0]];
   endfunction

   // Source lane of output lane i after the word permutation.
   function automatic logic [3:0] perm_at(input logic wide, input logic [3:0] i);
      return wide ? PERM16[i] : (i[3] ? i : PERM8[i[2:0]]);
   endfunction

   // Source lane for undoing the word permutation.
   function automatic logic [3:0] iperm_at(input logic wide, input logic [3:0] i);
      return wide ? IPERM16[i] : (i[3] ? i : IPERM8[i[2:0]]);
   endfunction

   function automatic word_type rotl(input word_type x, input logic [5:0] n);
      logic [127:0] w;
      w = {x, x} << n;
      return w[127:64];
   endfunction

   function automatic word_type rotr(input word_type x, input logic [5:0] n);
      logic [127:0] w;
      w = {x, x} >> n;
      return w[63:0];
   endfunction

endpackage

[hw/rtl/thf_req_if.sv]
// Input channel: key, tweak and data word loads.
interface thf_req_if;
   import thf_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [3:0] word_index;
   logic [63:0] word_value;
   modport source (output valid, req_type, word_index, word_value, input ready);
   modport sink   (input valid, req_type, word_index, word_value, output ready);
endinterface

[hw/rtl/thf_rsp_if.sv]
// Result channel: processed block words in index order.
interface thf_rsp_if;
   import thf_pkg::*;
   logic       valid;
   logic       ready;
   logic [3:0] out_index;
   logic [63:0] out_word;
   logic       last_word;
   modport source (output valid, out_index, out_word, last_word, input ready);
   modport sink   (input valid, out_index, out_word, last_word, output ready);
endinterface

[hw/rtl/thf_ctrl.sv]
// Sequencer for load, key injection, mixing rounds and result emission.
module thf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  thf_pkg::status_type status,
   input  logic               rsp_fire,
   output thf_pkg::cmd_type   cmd,
   output logic               req_ready,
   output logic               rsp_valid,
   output logic [3:0]         out_index,
   output logic               last_word
);
   import thf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOAD   = 5'b00010,
      ST_INJECT = 5'b00100,
      ST_MIX    = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] rnd_ff, rnd_in;
   logic [4:0] inj_ff, inj_in;
   logic [3:0] idx_ff, idx_in;
   windex_type last_idx;
   logic [4:0] inj_last;

   assign last_idx = status.wide ? LAST_WIDE : LAST_NARROW;
   assign inj_last = status.wide ? INJ_LAST_WIDE : INJ_LAST_NARROW;

   // Next state and counters.
   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      inj_in   = inj_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.trigger) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            inj_in   = '0;
            state_in = ST_INJECT;
         end
         ST_INJECT: begin
            rnd_in = '0;
            idx_in = '0;
            if (inj_ff == inj_last) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MIX;
            end
            inj_in = inj_ff + 5'd1;
         end
         ST_MIX: begin
            rnd_in = rnd_ff + 2'd1;
            if (rnd_ff == 2'd3) state_in = ST_INJECT;
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               idx_in = idx_ff + 4'd1;
               if (idx_ff == last_idx) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
         inj_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         inj_ff   <= inj_in;
         idx_ff   <= idx_in;
      end
   end

   // Commands and handshake outputs.
   assign cmd.load   = (state_ff == ST_LOAD);
   assign cmd.inject = (state_ff == ST_INJECT);
   assign cmd.mix    = (state_ff == ST_MIX);
   assign cmd.shift  = rsp_fire;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_EMIT);
   assign out_index  = idx_ff;
   assign last_word  = (idx_ff == last_idx);

endmodule

[hw/rtl/thf_datapath.sv]
// Word stores, key schedule registers and the shared Threefish round unit.
module thf_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic [1:0]         req_kind,
   input  logic [3:0]         req_index,
   input  logic [63:0]        req_value,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic               csr_wdata,
   input  thf_pkg::cmd_type   cmd,
   output thf_pkg::status_type status,
   output logic [63:0]        rsp_word
);
   import thf_pkg::*;

   word_type   key_ff [MaxWords];
   word_type   tweak_ff [2];
   word_type   buf_ff [MaxWords];
   word_type   v_ff [MaxWords], v_in [MaxWords];
   word_type   kr_ff [KeyWords], kr_in [KeyWords];
   word_type   tr_ff [3], tr_in [3];
   logic [4:0] s_ff, s_in;
   logic [2:0] d_ff, d_in;
   logic       wide_ff, dec_ff;

   word_type   kfull [KeyWords];
   word_type   kx;
   word_type   sk [MaxWords];
   word_type   mix_tmp [MaxWords];
   windex_type last_idx;
   logic       in_range;

   assign last_idx = wide_ff ? LAST_WIDE : LAST_NARROW;
   assign in_range = wide_ff | ~req_index[3];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff <= 1'b0;
         dec_ff  <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == CSR_WIDE_BLOCK)   wide_ff <= csr_wdata;
         if (csr_index == CSR_DECRYPT_MODE) dec_ff  <= csr_wdata;
      end
   end

   // Key and tweak stores clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MaxWords; i++) key_ff[i] <= '0;
         tweak_ff[0] <= '0;
         tweak_ff[1] <= '0;
      end else if (req_fire) begin
         if (req_kind == REQ_KEY && in_range) key_ff[req_index] <= req_value;
         if (req_kind == REQ_TWEAK && req_index[3:1] == 3'd0) tweak_ff[req_index[0]] <= req_value;
      end
   end

   // Block buffer holds loaded data words.
   always_ff @(posedge clock) begin
      if (req_fire && req_kind == REQ_DATA && in_range) buf_ff[req_index] <= req_value;
   end

   assign status.trigger = req_fire && req_kind == REQ_DATA && req_index == last_idx;
   assign status.wide    = wide_ff;

   // Extended key: the constant XOR all key words of the block.
   always_comb begin
      kx = KsConst;
      for (int i = 0; i < MaxWords; i++) begin
         if (wide_ff || i < 8) kx = kx ^ key_ff[i];
      end
      for (int i = 0; i < MaxWords; i++) kfull[i] = key_ff[i];
      kfull[MaxWords] = kx;
      if (!wide_ff) kfull[8] = kx;
   end

   // Subkey words from the rotating key and tweak registers.
   always_comb begin
      for (int i = 0; i < MaxWords; i++) begin
         sk[i] = kr_ff[i];
         if (4'(i) == last_idx - 4'd2) sk[i] = kr_ff[i] + tr_ff[0];
         else if (4'(i) == last_idx - 4'd1) sk[i] = kr_ff[i] + tr_ff[1];
         else if (4'(i) == last_idx) sk[i] = kr_ff[i] + {59'd0, s_ff};
      end
   end

   // Mixing round, forward or inverse, over all word pairs.
   always_comb begin
      word_type a, b, t_s;
      logic [5:0] r;
      a   = '0;
      b   = '0;
      t_s = '0;
      r   = '0;
      for (int i = 0; i < MaxWords; i++) mix_tmp[i] = '0;
      if (!dec_ff) begin
         for (int j = 0; j < MaxWords / 2; j++) begin
            a = v_ff[2*j];
            b = v_ff[2*j+1];
            r = rot_amt(wide_ff, d_ff, 3'(j));
            mix_tmp[2*j]   = a + b;
            mix_tmp[2*j+1] = rotl(b, r) ^ (a + b);
         end
      end else begin
         for (int j = 0; j < MaxWords / 2; j++) begin
            t_s = v_ff[iperm_at(wide_ff, 4'(2*j))];
            b   = v_ff[iperm_at(wide_ff, 4'(2*j+1))] ^ t_s;
            r   = rot_amt(wide_ff, d_ff, 3'(j));
            b   = rotr(b, r);
            mix_tmp[2*j]   = t_s - b;
            mix_tmp[2*j+1] = b;
         end
      end
   end

   // Next values of the working block and key schedule.
   always_comb begin
      for (int i = 0; i < MaxWords; i++) v_in[i] = v_ff[i];
      for (int i = 0; i < KeyWords; i++) kr_in[i] = kr_ff[i];
      for (int i = 0; i < 3; i++) tr_in[i] = tr_ff[i];
      s_in = s_ff;
      d_in = d_ff;
      if (cmd.load) begin
         for (int i = 0; i < MaxWords; i++) v_in[i] = buf_ff[i];
         if (dec_ff && wide_ff) begin
            for (int i = 0; i < KeyWords; i++) kr_in[i] = kfull[(i + 3) % KeyWords];
            tr_in[0] = tweak_ff[0] ^ tweak_ff[1];
            tr_in[1] = tweak_ff[0];
            tr_in[2] = tweak_ff[1];
         end else begin
            for (int i = 0; i < KeyWords; i++) kr_in[i] = kfull[i];
            tr_in[0] = tweak_ff[0];
            tr_in[1] = tweak_ff[1];
            tr_in[2] = tweak_ff[0] ^ tweak_ff[1];
         end
         s_in = dec_ff ? (wide_ff ? INJ_LAST_WIDE : INJ_LAST_NARROW) : 5'd0;
         d_in = dec_ff ? 3'd7 : 3'd0;
      end else if (cmd.inject) begin
         for (int i = 0; i < MaxWords; i++)
            v_in[i] = dec_ff ? v_ff[i] - sk[i] : v_ff[i] + sk[i];
         if (!dec_ff) begin
            for (int i = 0; i < MaxWords; i++) begin
               if (!wide_ff && i == 8) kr_in[i] = kr_ff[0];
               else kr_in[i] = kr_ff[i+1];
            end
            kr_in[MaxWords] = kr_ff[0];
            tr_in[0] = tr_ff[1];
            tr_in[1] = tr_ff[2];
            tr_in[2] = tr_ff[0];
            s_in = s_ff + 5'd1;
         end else begin
            kr_in[0] = wide_ff ? kr_ff[MaxWords] : kr_ff[8];
            for (int i = 1; i < KeyWords; i++) kr_in[i] = kr_ff[i-1];
            tr_in[0] = tr_ff[2];
            tr_in[1] = tr_ff[0];
            tr_in[2] = tr_ff[1];
            s_in = s_ff - 5'd1;
         end
      end else if (cmd.mix) begin
         if (!dec_ff) begin
            for (int i = 0; i < MaxWords; i++) v_in[i] = mix_tmp[perm_at(wide_ff, 4'(i))];
            d_in = d_ff + 3'd1;
         end else begin
            for (int i = 0; i < MaxWords; i++) v_in[i] = mix_tmp[i];
            d_in = d_ff - 3'd1;
         end
      end else if (cmd.shift) begin
         for (int i = 0; i < MaxWords - 1; i++) v_in[i] = v_ff[i+1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxWords; i++) v_ff[i] <= v_in[i];
      for (int i = 0; i < KeyWords; i++) kr_ff[i] <= kr_in[i];
      for (int i = 0; i < 3; i++) tr_ff[i] <= tr_in[i];
      s_ff <= s_in;
      d_ff <= d_in;
   end

   assign rsp_word = v_ff[0];

endmodule

[hw/rtl/threefish_block_cipher.sv]
// Threefish-512/1024 block cipher: one mixing round or key injection per cycle.
// A block takes a load, then 19 or 21 key injections (512 or 1024) with four mixing
// rounds between each pair, 72 or 80 rounds in all, in the shared round unit.
// Results then leave one word per cycle while the sink is ready; a block of 8 or 16 items.
// Loads are taken one per cycle; no item is accepted while a block is in flight.
// Synchronous reset clears key, tweak and configuration; the data buffer is not cleared.
module threefish_block_cipher (
   input  logic       clock,
   input  logic       reset,
   thf_req_if.sink    req_if,
   thf_rsp_if.source  rsp_if,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic       csr_wdata
);
   import thf_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;

   thf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .rsp_fire  (rsp_fire),
      .cmd       (cmd),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .out_index (rsp_if.out_index),
      .last_word (rsp_if.last_word)
   );

   thf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_kind  (req_if.req_type),
      .req_index (req_if.word_index),
      .req_value (req_if.word_value),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_word  (rsp_if.out_word)
   );

`ifndef SYNTHESIS
   // No item is taken while results are being delivered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready) else $error("item accepted during emission");

   // The final word carries the block's last index.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.last_word) |->
         (rsp_if.out_index == LAST_NARROW || rsp_if.out_index == LAST_WIDE))
      else $error("last word at wrong index");

   // After the final word the block is ready for new items.
   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_if.last_word) |=> req_if.ready) else $error("not idle after block");
`endif

endmodule
